// ----- sv/crc32_msb_first_stream_defines.svh -----
// assertion macros for the crc32 msb-first stream block
// used by the top level, which must have i_clk and i_rst_n in scope
`ifndef CRC32_MSB_FIRST_STREAM_DEFINES_SVH
`define CRC32_MSB_FIRST_STREAM_DEFINES_SVH

// antecedent in this cycle implies consequent in the next
`define CRC32MS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

// antecedent implies consequent in the same cycle
`define CRC32MS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

`endif

// ----- sv/crc32ms_pkg.sv -----
// shared types and constants for the crc32 msb-first stream block
// no dependencies
package crc32ms_pkg;

    localparam int BYTE_FIELDS = 4;
    localparam int GROUP_BITS  = 8;

    typedef logic [7:0]  t_byte;
    typedef logic [31:0] t_word;
    typedef t_word [GROUP_BITS-1:0] t_group;

    localparam t_word CRC_PRESET = 32'hFFFF_FFFF;
    localparam t_word POLY_RESET = 32'h04C1_1DB7;

endpackage

// ----- sv/crc32ms_table.sv -----
// polynomial register and the x^(32+k) mod p reduction table, built by a sweep
// of one eight-entry group per cycle after reset and after every polynomial write
// depends on crc32ms_pkg
module crc32ms_table #(
    parameter int LANES = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  crc32ms_pkg::t_word  i_cfg_data,
    output logic                o_busy,
    output crc32ms_pkg::t_group o_grp [LANES]
);
    import crc32ms_pkg::*;

    localparam int    STEP_W    = (LANES > 1) ? $clog2(LANES) : 1;
    localparam t_word TOP_SEED  = 32'h8000_0000;

    logic              r_busy;
    logic [STEP_W-1:0] r_step;
    t_word             r_poly;
    t_word             r_seed;
    t_group            r_grp [LANES];
    t_group            chain;

    function automatic t_word shift1(input t_word v, input t_word poly);
        shift1 = {v[30:0], 1'b0} ^ (v[31] ? poly : '0);
    endfunction

    always_comb begin
        chain[0] = shift1(r_seed, r_poly);
        for (int k = 1; k < GROUP_BITS; k++) begin
            chain[k] = shift1(chain[k-1], r_poly);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_step <= '0;
            r_poly <= POLY_RESET;
            r_seed <= TOP_SEED;
        end else if (i_cfg_we) begin
            r_busy <= 1'b1;
            r_step <= '0;
            r_poly <= i_cfg_data;
            r_seed <= TOP_SEED;
        end else if (r_busy) begin
            r_seed <= chain[GROUP_BITS-1];
            r_step <= r_step + 1'b1;
            if (r_step == STEP_W'(LANES - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy && !i_cfg_we) begin
            for (int g = 0; g < LANES; g++) begin
                if (r_step == STEP_W'(g)) begin
                    r_grp[g] <= chain;
                end
            end
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_grp
        assign o_grp[g] = r_grp[g];
    end

    assign o_busy = r_busy;

endmodule

// ----- sv/crc32ms_lane.sv -----
// one byte lane: folds eight augmented bits against its group of reduction terms
// depends on crc32ms_pkg
module crc32ms_lane (
    input  crc32ms_pkg::t_byte  i_h,
    input  crc32ms_pkg::t_group i_grp,
    output crc32ms_pkg::t_word  o_part
);
    import crc32ms_pkg::*;

    always_comb begin
        o_part = '0;
        for (int b = 0; b < GROUP_BITS; b++) begin
            o_part = o_part ^ (i_h[b] ? i_grp[b] : '0);
        end
    end

endmodule

// ----- sv/crc32_msb_first_stream.sv -----
// crc32 msb-first stream: lanes, merge into the remainder, output register
// depends on crc32ms_pkg, crc32ms_table, crc32ms_lane, crc32_msb_first_stream_defines.svh
//
// input channel: i_valid / o_stall with bytes a..d, byte count, first and last.
// an item is taken when i_valid is high and o_stall low; up to four bytes are
// folded at once, so one item per cycle is sustained while o_stall is low.
// output channel: o_valid / i_stall with o_crc_value. an item with last set
// gives its result in the cycle after it is taken, held in an output register.
// while a result waits, items without last are still taken; an item with last
// is held off until the waiting result leaves or leaves in the same cycle.
// polynomial: i_cfg_we / i_cfg_data, written while i_cfg_we is high. after every write and
// after reset the reduction table is rebuilt, one group of eight terms a cycle:
// o_stall is high in the write cycle and then until a group is built for every lane (four at most).
// reset: remainder all ones, polynomial 0x04C11DB7, no result pending.
// byte counts above the lane count saturate; a count of zero folds nothing.
module crc32_msb_first_stream #(
    parameter int BYTES_PER_ITEM = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  crc32ms_pkg::t_word i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  crc32ms_pkg::t_byte i_byte_a,
    input  crc32ms_pkg::t_byte i_byte_b,
    input  crc32ms_pkg::t_byte i_byte_c,
    input  crc32ms_pkg::t_byte i_byte_d,
    input  logic [2:0]         i_byte_count,
    input  logic               i_first,
    input  logic               i_last,
    output logic               o_valid,
    input  logic               i_stall,
    output crc32ms_pkg::t_word o_crc_value
);
    import crc32ms_pkg::*;

    localparam int LANES = (BYTES_PER_ITEM < BYTE_FIELDS) ? BYTES_PER_ITEM : BYTE_FIELDS;

    logic       tbl_busy;
    t_group     grp   [LANES];
    t_byte      h     [LANES];
    t_word      part  [LANES];
    t_byte      bytes [BYTE_FIELDS];
    logic [2:0] cnt;
    logic       in_acc;
    t_word      rem_pre;
    t_word      n_rem;
    t_word      r_rem;
    logic       r_out_valid;
    t_word      r_crc;

    crc32ms_table #(
        .LANES (LANES)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_busy     (tbl_busy),
        .o_grp      (grp)
    );

    assign bytes[0] = i_byte_a;
    assign bytes[1] = i_byte_b;
    assign bytes[2] = i_byte_c;
    assign bytes[3] = i_byte_d;

    assign cnt     = (i_byte_count > 3'(LANES)) ? 3'(LANES) : i_byte_count;
    assign rem_pre = i_first ? CRC_PRESET : r_rem;

    // lane g takes the byte that lands at augmented position g
    always_comb begin
        for (int g = 0; g < LANES; g++) begin
            h[g] = '0;
            for (int j = 0; j < LANES; j++) begin
                if (j + g + 1 == int'(cnt)) begin
                    h[g] = bytes[j] ^ rem_pre[31 - 8*j -: 8];
                end
            end
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        crc32ms_lane u_lane (
            .i_h    (h[g]),
            .i_grp  (grp[g]),
            .o_part (part[g])
        );
    end

    // merge
    always_comb begin
        n_rem = rem_pre << {cnt, 3'b000};
        for (int g = 0; g < LANES; g++) begin
            n_rem = n_rem ^ part[g];
        end
    end

    assign o_stall = tbl_busy || i_cfg_we || (r_out_valid && i_stall && i_last);
    assign in_acc  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem       <= CRC_PRESET;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_rem <= n_rem;
            end
            if (in_acc && i_last) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_last) begin
            r_crc <= ~n_rem;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_crc_value = r_crc;

`include "crc32_msb_first_stream_defines.svh"

`CRC32MS_ASSERT_NEXT(a_last_gives_result, in_acc && i_last, o_valid, "no result after last item")
`CRC32MS_ASSERT_NEXT(a_result_matches_rem, in_acc && i_last, o_crc_value == ~r_rem, "result not complement of remainder")
`CRC32MS_ASSERT_NEXT(a_rem_holds, !in_acc, $stable(r_rem), "remainder moved without an item")
`CRC32MS_ASSERT_NEXT(a_cfg_rebuilds, i_cfg_we, o_stall, "item taken during table rebuild")

endmodule

// ----- tb/sv/tb_top.sv -----
// testbench for crc32_msb_first_stream: a bitwise crc predictor fed from the input
// handshake, compared with every result item, under random idling and back-pressure
// depends on crc32ms_pkg and crc32_msb_first_stream
module tb_top;
    import crc32ms_pkg::*;

    localparam int LANES        = 4;
    localparam int DRAIN_CYCLES = 4;
    localparam int HOLD_CYCLES  = 80;
    localparam int QUIET_LIMIT  = 1000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    t_word      i_cfg_data;
    logic       i_valid;
    logic       o_stall;
    t_byte      i_byte_a;
    t_byte      i_byte_b;
    t_byte      i_byte_c;
    t_byte      i_byte_d;
    logic [2:0] i_byte_count;
    logic       i_first;
    logic       i_last;
    logic       o_valid;
    logic       i_stall;
    t_word      o_crc_value;

    t_word crc_remainder = CRC_PRESET;
    t_word crc_poly      = POLY_RESET;
    t_word crc_expected[$];
    t_word crc_want;
    int    error_count   = 0;
    int    items_sent    = 0;
    int    quiet_cycles  = 0;
    bit    tx_idle_on    = 1'b0;
    bit    rx_idle_on    = 1'b0;
    bit    rx_hold_req   = 1'b0;

    crc32_msb_first_stream u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_byte_a     (i_byte_a),
        .i_byte_b     (i_byte_b),
        .i_byte_c     (i_byte_c),
        .i_byte_d     (i_byte_d),
        .i_byte_count (i_byte_count),
        .i_first      (i_first),
        .i_last       (i_last),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_crc_value  (o_crc_value)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_word crc_fold_byte(input t_word rem, input t_byte octet,
                                            input t_word poly);
        logic fb;
        for (int k = 7; k >= 0; k--) begin
            fb  = octet[k] ^ rem[31];
            rem = rem << 1;
            if (fb) begin
                rem = rem ^ poly;
            end
        end
        return rem;
    endfunction

    task automatic report_mismatch(input string what, input t_word want, input t_word got);
        $display("mismatch on %s: expected %08h, got %08h at %0t", what, want, got, $time);
        error_count++;
    endtask

    task automatic send_item(input t_byte a, input t_byte b, input t_byte c, input t_byte d,
                             input logic [2:0] cnt, input logic fst, input logic lst);
        int    n;
        t_byte lane [LANES];
        if (tx_idle_on && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_byte_a     <= a;
        i_byte_b     <= b;
        i_byte_c     <= c;
        i_byte_d     <= d;
        i_byte_count <= cnt;
        i_first      <= fst;
        i_last       <= lst;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        lane = '{a, b, c, d};
        n = (cnt > LANES) ? LANES : int'(cnt);
        if (fst) begin
            crc_remainder = CRC_PRESET;
        end
        for (int i = 0; i < n; i++) begin
            crc_remainder = crc_fold_byte(crc_remainder, lane[i], crc_poly);
        end
        if (lst) begin
            crc_expected.push_back(~crc_remainder);
        end
        items_sent++;
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (crc_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_polynomial(input t_word value);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        crc_poly = value;
    endtask

    task automatic send_message(input int n_items, input bit clean);
        logic [31:0] w;
        logic [2:0]  cnt;
        logic        fst;
        logic        lst;
        int          r;
        for (int j = 0; j < n_items; j++) begin
            w = $urandom;
            r = $urandom_range(0, 19);
            if (r == 0) begin
                cnt = 3'd0;
            end else if (r == 1) begin
                cnt = 3'($urandom_range(5, 7));
            end else begin
                cnt = 3'($urandom_range(1, 4));
            end
            fst = clean ? (j == 0) : 1'($urandom_range(0, 1));
            lst = clean ? (j == n_items - 1) : 1'($urandom_range(0, 1));
            send_item(w[7:0], w[15:8], w[23:16], w[31:24], cnt, fst, lst);
        end
    endtask

    task automatic test_default_polynomial();
        send_item(8'h31, 8'h32, 8'h33, 8'h34, 3'd4, 1'b1, 1'b0);
        send_item(8'h35, 8'h36, 8'h37, 8'h38, 3'd4, 1'b0, 1'b0);
        send_item(8'h39, 8'h00, 8'h00, 8'h00, 3'd1, 1'b0, 1'b1);
        send_item(8'h00, 8'h00, 8'h00, 8'h00, 3'd4, 1'b1, 1'b1);
        send_item(8'hff, 8'hff, 8'hff, 8'hff, 3'd4, 1'b1, 1'b1);
        send_item(8'ha5, 8'h5a, 8'hc3, 8'h3c, 3'd0, 1'b1, 1'b1);
    endtask

    task automatic test_byte_counts();
        send_item(8'h12, 8'h34, 8'h56, 8'h78, 3'd5, 1'b1, 1'b1);
        send_item(8'h9a, 8'hbc, 8'hde, 8'hf0, 3'd6, 1'b1, 1'b1);
        send_item(8'h01, 8'h80, 8'h7f, 8'hfe, 3'd7, 1'b1, 1'b1);
        send_item(8'hde, 8'had, 8'hbe, 8'hef, 3'd2, 1'b1, 1'b0);
        send_item(8'hff, 8'hff, 8'hff, 8'hff, 3'd0, 1'b0, 1'b0);
        send_item(8'h55, 8'haa, 8'h00, 8'hff, 3'd3, 1'b0, 1'b1);
    endtask

    task automatic test_carry_on();
        send_item(8'h61, 8'h62, 8'h63, 8'h64, 3'd4, 1'b1, 1'b0);
        send_item(8'h65, 8'h66, 8'h67, 8'h68, 3'd3, 1'b0, 1'b1);
        send_item(8'h69, 8'h6a, 8'h6b, 8'h6c, 3'd4, 1'b0, 1'b1);
        send_item(8'h6d, 8'h6e, 8'h6f, 8'h70, 3'd1, 1'b0, 1'b0);
        send_item(8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 1'b0, 1'b1);
    endtask

    task automatic test_polynomial_extremes();
        write_polynomial(32'h0000_0000);
        send_item(8'h80, 8'h01, 8'hff, 8'h00, 3'd4, 1'b1, 1'b0);
        send_item(8'h7e, 8'he7, 8'h18, 8'h81, 3'd4, 1'b0, 1'b1);
        write_polynomial(32'hffff_ffff);
        send_item(8'h80, 8'h01, 8'hff, 8'h00, 3'd4, 1'b1, 1'b0);
        send_item(8'h7e, 8'he7, 8'h18, 8'h81, 3'd4, 1'b0, 1'b1);
    endtask

    task automatic test_random_messages(input int n_items, input t_word poly);
        int start;
        write_polynomial(poly);
        start = items_sent;
        while (items_sent - start < n_items) begin
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            send_message($urandom_range(1, 6), $urandom_range(0, 9) != 0);
        end
    endtask

    task automatic test_backpressure();
        tx_idle_on  = 1'b0;
        rx_idle_on  = 1'b0;
        rx_hold_req = 1'b1;
        for (int m = 0; m < 25; m++) begin
            send_message($urandom_range(1, 2), 1'b1);
        end
    endtask

    task automatic test_final_stretch();
        int start;
        write_polynomial(POLY_RESET);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        start = items_sent;
        while (items_sent - start < 100) begin
            send_message($urandom_range(1, 6), $urandom_range(0, 9) != 0);
        end
    endtask

    // receiver side: random stall bursts and one long hold-off on request
    initial begin
        i_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_stall <= 1'b0;
                rx_hold_req = 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // result check and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (o_valid === 1'b1 && i_stall === 1'b0) begin
                if (crc_expected.size() == 0) begin
                    report_mismatch("unexpected result", 32'h0, o_crc_value);
                end else begin
                    crc_want = crc_expected.pop_front();
                    if (o_crc_value !== crc_want) begin
                        report_mismatch("crc_value", crc_want, o_crc_value);
                    end
                end
            end
            if ((i_valid === 1'b1 && o_stall === 1'b0) ||
                (o_valid === 1'b1 && i_stall === 1'b0)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_data   <= '0;
        i_valid      <= 1'b0;
        i_byte_a     <= '0;
        i_byte_b     <= '0;
        i_byte_c     <= '0;
        i_byte_d     <= '0;
        i_byte_count <= '0;
        i_first      <= 1'b0;
        i_last       <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_polynomial();
        test_byte_counts();
        test_carry_on();
        test_polynomial_extremes();
        test_random_messages(120, POLY_RESET);
        test_random_messages(120, $urandom);
        test_backpressure();
        test_random_messages(120, 32'h1edc_6f41);
        test_final_stretch();
        drain_results();
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+sv
sv/crc32ms_pkg.sv
sv/crc32ms_table.sv
sv/crc32ms_lane.sv
sv/crc32_msb_first_stream.sv
tb/sv/tb_top.sv
